/* rtl/nim_pkg.sv */
// Types and GF(2) helper functions for the 64-bit nimber multiplier pipeline.
`default_nettype none

package nim_pkg;

  localparam int unsigned OperandWidth = 64;

  // Operand pieces after each halving step: three pieces per split.
  typedef logic [2:0][31:0]  piece32_t;
  typedef logic [8:0][15:0]  piece16_t;
  typedef logic [26:0][7:0]  piece8_t;

  // Multiplication by the Fermat element 2^(N-1) inside the N-bit field.
  // It is linear over GF(2), so each function is a fixed XOR network.
  function automatic logic [1:0] mulc2(input logic [1:0] x);
    return {x[1] ^ x[0], x[1]};
  endfunction

  function automatic logic [3:0] mulc4(input logic [3:0] x);
    return {mulc2(x[3:2] ^ x[1:0]), mulc2(mulc2(x[3:2]))};
  endfunction

  function automatic logic [7:0] mulc8(input logic [7:0] x);
    return {mulc4(x[7:4] ^ x[3:0]), mulc4(mulc4(x[7:4]))};
  endfunction

  function automatic logic [15:0] mulc16(input logic [15:0] x);
    return {mulc8(x[15:8] ^ x[7:0]), mulc8(mulc8(x[15:8]))};
  endfunction

  // Full nimber products for the narrow widths.
  function automatic logic [1:0] nim2(input logic [1:0] a, input logic [1:0] b);
    logic hh;
    logic ll;
    logic mm;
    hh = a[1] & b[1];
    ll = a[0] & b[0];
    mm = (a[1] ^ a[0]) & (b[1] ^ b[0]);
    return {ll ^ mm, hh ^ ll};
  endfunction

  function automatic logic [3:0] nim4(input logic [3:0] a, input logic [3:0] b);
    logic [1:0] hh;
    logic [1:0] ll;
    logic [1:0] mm;
    hh = nim2(a[3:2], b[3:2]);
    ll = nim2(a[1:0], b[1:0]);
    mm = nim2(a[3:2] ^ a[1:0], b[3:2] ^ b[1:0]);
    return {ll ^ mm, mulc2(hh) ^ ll};
  endfunction

  function automatic logic [7:0] nim8(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] hh;
    logic [3:0] ll;
    logic [3:0] mm;
    hh = nim4(a[7:4], b[7:4]);
    ll = nim4(a[3:0], b[3:0]);
    mm = nim4(a[7:4] ^ a[3:0], b[7:4] ^ b[3:0]);
    return {ll ^ mm, mulc4(hh) ^ ll};
  endfunction

  // Recombination of the high, low and cross half products into one product.
  function automatic logic [15:0] join16(input logic [7:0] hh, input logic [7:0] ll,
                                         input logic [7:0] mm);
    return {ll ^ mm, mulc8(hh) ^ ll};
  endfunction

  function automatic logic [31:0] join32(input logic [15:0] hh, input logic [15:0] ll,
                                         input logic [15:0] mm);
    return {ll ^ mm, mulc16(hh) ^ ll};
  endfunction

  function automatic logic [63:0] join64(input logic [31:0] hh, input logic [31:0] ll,
                                         input logic [31:0] mm);
    logic [31:0] hc;
    hc = {mulc16(hh[31:16] ^ hh[15:0]), mulc16(mulc16(hh[31:16]))};
    return {ll ^ mm, hc ^ ll};
  endfunction

endpackage

`default_nettype wire

/* rtl/nimber_multiplier_64.sv */
// Top level of the five-stage pipelined 64-bit nimber multiplier.
//
// The block multiplies two 64-bit values in Conway's nimber field GF(2^64).
// Input beats arrive on the s_ channel: s_tdata carries left_operand in bits
// 63:0 and right_operand in bits 127:64. Each accepted beat gives exactly one
// result beat on the m_ channel, with the product in m_tdata, in input order.
//
// Throughput is one product per cycle unless m_tready stalls the output;
// every stage is a register, and the depth of the product unit sets the stage
// count: one stage splits the operands into 27 byte pairs, one forms the 27
// byte products, and three stages fold them back through 16, 32 and 64 bits.
//
// Each stage holds a valid bit. A stage loads whenever it is empty or its
// successor is loading, so bubbles close up and a stall of m_tready holds
// every full stage in place: nothing is lost or repeated. s_tready falls only
// when all five stages are full and the output is stalled.
//
// Synchronous reset empties the pipeline; the data registers are not reset.
`default_nettype none

module nimber_multiplier_64 import nim_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [2*OperandWidth-1:0]   s_tdata,  // left_operand, right_operand
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [OperandWidth-1:0]     m_tdata   // nim_result
);

  // Valid bits for the five stages.
  logic [4:0] valid;
  logic [4:0] load;

  // Stage payloads.
  piece8_t             a8;
  piece8_t             b8;
  piece8_t             p8;
  piece16_t            p16;
  piece32_t            p32;
  logic [63:0]         product;

  // Combinational operand splitting and stage results.
  piece32_t  a32_next;
  piece32_t  b32_next;
  piece16_t  a16_next;
  piece16_t  b16_next;
  piece8_t   a8_next;
  piece8_t   b8_next;
  piece8_t   p8_next;
  piece16_t  p16_next;
  piece32_t  p32_next;
  logic [63:0] product_next;

  // A stage loads when it is empty or its successor is taking its contents.
  always_comb begin
    load[4] = !valid[4] || m_tready;
    load[3] = !valid[3] || load[4];
    load[2] = !valid[2] || load[3];
    load[1] = !valid[1] || load[2];
    load[0] = !valid[0] || load[1];
  end

  assign s_tready = load[0];
  assign m_tvalid = valid[4];
  assign m_tdata  = product;

  // Each split gives the high half, the low half and their XOR, in that order.
  always_comb begin
    a32_next[0] = s_tdata[63:32];
    a32_next[1] = s_tdata[31:0];
    a32_next[2] = s_tdata[63:32] ^ s_tdata[31:0];
    b32_next[0] = s_tdata[127:96];
    b32_next[1] = s_tdata[95:64];
    b32_next[2] = s_tdata[127:96] ^ s_tdata[95:64];
    for (int i = 0; i < 3; i++) begin
      a16_next[3*i]   = a32_next[i][31:16];
      a16_next[3*i+1] = a32_next[i][15:0];
      a16_next[3*i+2] = a32_next[i][31:16] ^ a32_next[i][15:0];
      b16_next[3*i]   = b32_next[i][31:16];
      b16_next[3*i+1] = b32_next[i][15:0];
      b16_next[3*i+2] = b32_next[i][31:16] ^ b32_next[i][15:0];
    end
    for (int i = 0; i < 9; i++) begin
      a8_next[3*i]   = a16_next[i][15:8];
      a8_next[3*i+1] = a16_next[i][7:0];
      a8_next[3*i+2] = a16_next[i][15:8] ^ a16_next[i][7:0];
      b8_next[3*i]   = b16_next[i][15:8];
      b8_next[3*i+1] = b16_next[i][7:0];
      b8_next[3*i+2] = b16_next[i][15:8] ^ b16_next[i][7:0];
    end
  end

  // Byte products, then three folding steps back up to the full width.
  always_comb begin
    for (int k = 0; k < 27; k++) begin
      p8_next[k] = nim8(a8[k], b8[k]);
    end
    for (int m = 0; m < 9; m++) begin
      p16_next[m] = join16(p8[3*m], p8[3*m+1], p8[3*m+2]);
    end
    for (int n = 0; n < 3; n++) begin
      p32_next[n] = join32(p16[3*n], p16[3*n+1], p16[3*n+2]);
    end
    product_next = join64(p32[0], p32[1], p32[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int s = 1; s < 5; s++) begin
        if (load[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a8 <= a8_next;
      b8 <= b8_next;
    end
    if (load[1]) begin
      p8 <= p8_next;
    end
    if (load[2]) begin
      p16 <= p16_next;
    end
    if (load[3]) begin
      p32 <= p32_next;
    end
    if (load[4]) begin
      product <= product_next;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/nim_product_checker.sv */
`timescale 1ns / 100ps
// Checker for the nimber multiplier: predicts each product and compares the result beats.
module nim_product_checker import nim_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [2*OperandWidth-1:0]   s_tdata,
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [OperandWidth-1:0]     m_tdata,
  output int                               mismatches,
  output int                               outstanding
);

  typedef struct packed {
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] product;
  } product_due_t;

  product_due_t products_due[$];

  // Products of every pair of bytes, built level by level from the one-bit field upwards.
  logic [7:0] byte_prod [0:255][0:255];

  initial begin : build_byte_table
    int unsigned h, a, b, ah, al, bh, bl;
    logic [7:0] hh, ll, mm;
    for (a = 0; a < 2; a++) begin
      for (b = 0; b < 2; b++) begin
        byte_prod[a][b] = 8'(a & b);
      end
    end
    for (h = 1; h < 8; h = h * 2) begin
      for (a = 0; a < (1 << (2 * h)); a++) begin
        for (b = 0; b < (1 << (2 * h)); b++) begin
          ah = a >> h;
          al = a & ((1 << h) - 1);
          bh = b >> h;
          bl = b & ((1 << h) - 1);
          hh = byte_prod[ah][bh];
          ll = byte_prod[al][bl];
          mm = byte_prod[ah ^ al][bh ^ bl];
          byte_prod[a][b] = ((ll ^ mm) << h) ^ byte_prod[hh][1 << (h - 1)] ^ ll;
        end
      end
    end
  end

  function automatic logic [15:0] gf16_mul(input logic [15:0] a, input logic [15:0] b);
    logic [7:0] hh, ll, mm;
    hh = byte_prod[a[15:8]][b[15:8]];
    ll = byte_prod[a[7:0]][b[7:0]];
    mm = byte_prod[a[15:8] ^ a[7:0]][b[15:8] ^ b[7:0]];
    return {ll ^ mm, byte_prod[hh][8'h80] ^ ll};
  endfunction

  function automatic logic [31:0] gf32_mul(input logic [31:0] a, input logic [31:0] b);
    logic [15:0] hh, ll, mm;
    hh = gf16_mul(a[31:16], b[31:16]);
    ll = gf16_mul(a[15:0], b[15:0]);
    mm = gf16_mul(a[31:16] ^ a[15:0], b[31:16] ^ b[15:0]);
    return {ll ^ mm, gf16_mul(hh, 16'h8000) ^ ll};
  endfunction

  function automatic logic [63:0] gf64_mul(input logic [63:0] a, input logic [63:0] b);
    logic [31:0] hh, ll, mm;
    hh = gf32_mul(a[63:32], b[63:32]);
    ll = gf32_mul(a[31:0], b[31:0]);
    mm = gf32_mul(a[63:32] ^ a[31:0], b[63:32] ^ b[31:0]);
    return {ll ^ mm, gf32_mul(hh, 32'h8000_0000) ^ ll};
  endfunction

  always @(posedge clk) begin : watch
    product_due_t due;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (products_due.size() == 0) begin
          $display("%0t: product beat with none due: expected nothing, got %h",
                   $time, m_tdata);
          mismatches <= mismatches + 1;
        end else begin
          due = products_due.pop_front();
          if (m_tdata !== due.product) begin
            $display("%0t: product of %h and %h: expected %h, got %h",
                     $time, due.lhs, due.rhs, due.product, m_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        due.lhs = s_tdata[63:0];
        due.rhs = s_tdata[127:64];
        due.product = gf64_mul(due.lhs, due.rhs);
        products_due.push_back(due);
      end
      outstanding <= products_due.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, operand stimulus and the verdict for the nimber multiplier.
module tb;
  import nim_pkg::*;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [2*OperandWidth-1:0]   s_tdata = '0;   // left_operand, right_operand
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [OperandWidth-1:0]     m_tdata;        // nim_result

  int mismatches;
  int outstanding;

  // While calm is set neither side idles, so the pipeline runs at full rate.
  bit calm = 1'b0;
  int ready_run = 0;

  nimber_multiplier_64 i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  nim_product_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Length of an idle stretch: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Operand mix: full-width words, narrow values that exercise the lower
  // subfields, single bits, the trivial factors zero and one, and words with
  // one bit cleared.
  function automatic logic [63:0] rand_operand();
    int roll;
    int w;
    logic [63:0] v;
    roll = $urandom_range(99);
    v = {$urandom, $urandom};
    if (roll < 55) return v;
    if (roll < 75) begin
      w = $urandom_range(63, 1);
      return v & ((64'd1 << w) - 64'd1);
    end
    if (roll < 85) return 64'd1 << $urandom_range(63);
    if (roll < 92) return 64'($urandom_range(1));
    return ~(64'd1 << $urandom_range(63));
  endfunction

  // The result side holds tready high or low for runs of random length, so
  // stalls land on every stage of the pipeline.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      ready_run <= 0;
    end else if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(3) != 0);
      ready_run <= idle_len();
    end
  end

  // Presents one operand pair and returns at the edge where the beat is taken.
  // It is entered just after a rising edge; tvalid stays high between
  // back-to-back beats rather than being dropped and raised again.
  task automatic offer_operands(input logic [63:0] lhs, input logic [63:0] rhs);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rhs, lhs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [63:0] lhs;
    logic [63:0] rhs;
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: zero and one as factors, all-ones, bits 63, 32, 31 and 16,
    // alternating patterns, and the smallest non-trivial square.
    offer_operands(64'd0, 64'd0);
    offer_operands(64'd0, '1);
    offer_operands('1, 64'd0);
    offer_operands(64'd1, '1);
    offer_operands('1, 64'd1);
    offer_operands(64'd1, 64'd1);
    offer_operands(64'd2, 64'd2);
    offer_operands('1, '1);
    offer_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    offer_operands(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000);
    offer_operands(64'h0000_0000_0001_0000, 64'h0000_0000_0001_0000);
    offer_operands(64'h0000_0000_8000_0000, 64'h0000_0000_8000_0000);
    offer_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    offer_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    offer_operands(64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000);
    offer_operands(64'd3, 64'h8000_0000_0000_0000);
    offer_operands({$urandom, $urandom}, 64'd1);
    offer_operands(64'd0, {$urandom, $urandom});
    offer_operands({$urandom, $urandom}, {$urandom, $urandom});

    // Random beats in phases; every other phase runs without any idling.
    for (i = 0; i < 1250; i++) begin
      if (i % 250 == 0) calm = ((i / 250) % 2 == 1);
      lhs = rand_operand();
      rhs = ($urandom_range(19) == 0) ? lhs : rand_operand();
      offer_operands(lhs, rhs);
    end
    s_tvalid <= 1'b0;

    // Let the checker's count settle, then drain the pipeline.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("nimber_multiplier_64: match");
    end else begin
      $display("nimber_multiplier_64: mismatch");
    end
    $finish;
  end

  // Far beyond the slowest correct run, with every beat delayed by the
  // longest gaps and stalls on both sides.
  initial begin
    #10_000_000;
    $display("nimber_multiplier_64: mismatch");
    $finish;
  end

endmodule
